>>> hdl/adaptive_flush_threshold_defines.svh
// Assertion macros for the flush threshold tracker.
`ifndef ADAPTIVE_FLUSH_THRESHOLD_DEFINES_SVH
`define ADAPTIVE_FLUSH_THRESHOLD_DEFINES_SVH
`ifndef SYNTH
`define AFT_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define AFT_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define AFT_ASSERT_IMP(label, clk, rst_n, a, c)
`define AFT_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

>>> hdl/aft_pkg.sv
// ----------------------------------------------------------------------------
// aft_pkg
// Types and constants shared by the flush threshold tracker.
// ----------------------------------------------------------------------------
`default_nettype none
package aft_pkg;
  localparam int FILE_SLOTS = 64;
  localparam int DEVICE_SLOTS = 8;

  typedef enum logic [1:0] {
    OP_OPEN = 2'd0, OP_CLOSE = 2'd1, OP_WRITE = 2'd2, OP_SYNC = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_SAME = 2'd0, KIND_DEC = 2'd1, KIND_INC = 2'd2
  } kind_t;

  localparam logic [2:0] REG_INITIAL = 3'd0;
  localparam logic [2:0] REG_FLOOR   = 3'd1;
  localparam logic [2:0] REG_CEILING = 3'd2;
  localparam logic [2:0] REG_HIGH    = 3'd3;
  localparam logic [2:0] REG_LOW     = 3'd4;

  typedef struct packed {
    logic [1:0]  operation;
    logic [5:0]  file_slot;
    logic [2:0]  device_slot;
    logic [30:0] byte_count;
    logic [31:0] elapsed_us;
    logic        sync_ok;
  } in_item_t;

  typedef struct packed {
    logic        tracked;
    logic        sync_request;
    logic [32:0] dirty_bytes;
    logic [31:0] flush_limit;
    logic [1:0]  adjust_kind;
  } out_item_t;

  // divider handshake
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;
endpackage
`default_nettype wire

>>> hdl/adaptive_flush_threshold.sv
// Adaptive flush threshold tracker. Slot records (dirty count, threshold,
// device) live in a synchronous memory, device thresholds in a small one; an
// event reads its slot, modifies it and writes back any change. The result
// register loads from S_EXEC for open, close, write, a failed sync and any
// event on an untracked slot; otherwise from S_OUT, reached via S_ADJ for a
// sync done that keeps the threshold, via S_MUL, S_SUM, S_ADJ (split reciprocal
// multiply) for one that scales it by 7/10 or 13/10, and via S_DIV, S_ADJ
// when elapsed time exceeds twice the high target, set by the 64-step
// bit-serial 64/32 divider. One event is handled at a time; the next is
// taken in S_IDLE; the input stalls while a result waits on a stalled output.
// ----------------------------------------------------------------------------
// adaptive_flush_threshold
// Tracks dirty bytes per file slot and adapts flush thresholds per device.
// ----------------------------------------------------------------------------
`default_nettype none
`include "adaptive_flush_threshold_defines.svh"
module adaptive_flush_threshold (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire aft_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output aft_pkg::out_item_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);
  import aft_pkg::*;

  localparam int SAW = (FILE_SLOTS > 1) ? $clog2(FILE_SLOTS) : 1;
  localparam int DAW = (DEVICE_SLOTS > 1) ? $clog2(DEVICE_SLOTS) : 1;
  localparam int REC_W = 33 + 32 + DAW;
  // ceil(2^36 * 13/10) and ceil(2^36 * 7/10); exact floors for 32-bit limits
  localparam logic [36:0] MUL_13_10 = 37'h14CCCCCCCD;
  localparam logic [36:0] MUL_7_10  = 37'h0B33333334;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_DIV, S_MUL, S_SUM, S_ADJ, S_OUT
  } state_t;

  state_t state_r;
  in_item_t item_r;
  logic [31:0] lim_init_r, lim_floor_r, lim_ceil_r, lat_high_r, lat_low_r;
  logic [FILE_SLOTS-1:0]   slot_valid_r;
  logic [DEVICE_SLOTS-1:0] dev_known_r;
  logic [31:0] dev_limit_mem [DEVICE_SLOTS];
  logic [31:0] dev_rd_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  out_item_t   out_r;
  logic [31:0] lim_r;
  logic [1:0]  kind_r;
  logic        dev_we;
  logic [DAW-1:0] dev_waddr;
  logic [31:0] dev_wdata;

  logic           rec_we;
  logic [REC_W-1:0] rec_wdata, rec_rdata;
  logic [SAW-1:0] slot_idx;
  logic [SAW-1:0] slot_raddr;
  logic           slot_in_range;
  logic [DAW-1:0] dev_idx;
  logic [DAW-1:0] dev_raddr;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [32:0] rec_dirty;
  logic [31:0] rec_limit;
  logic [DAW-1:0] rec_dev;
  logic [32:0] dirty_sum;
  logic [32:0] high_x2;

  logic [36:0] mul_k;
  logic [52:0] pp_lo_r, pp_hi_r;
  logic [68:0] mul_sum;
  logic [32:0] mul_q_r;
  logic [31:0] adj_lim;

  out_item_t exec_out;
  state_t    exec_next;
  kind_t     exec_kind;

  assign slot_idx = item_r.file_slot[SAW-1:0];
  assign slot_in_range = ({26'd0, item_r.file_slot} < 32'(FILE_SLOTS));
  assign dev_idx = item_r.device_slot[DAW-1:0];
  // address from the offered beat while idle, then hold on the accepted one
  assign slot_raddr = (state_r == S_IDLE) ? in_data.file_slot[SAW-1:0] : slot_idx;
  assign dev_raddr = (state_r == S_IDLE) ? in_data.device_slot[DAW-1:0] : dev_idx;
  assign rec_dirty = rec_rdata[REC_W-1 -: 33];
  assign rec_limit = rec_rdata[DAW+31 -: 32];
  assign rec_dev = rec_rdata[DAW-1:0];
  assign dirty_sum = rec_dirty + {2'b0, item_r.byte_count};
  assign high_x2 = {lat_high_r, 1'b0};
  assign mul_k = (kind_r == KIND_INC) ? MUL_13_10 : MUL_7_10;
  assign mul_sum = {pp_hi_r, 16'd0} + {16'd0, pp_lo_r};

  aft_slot_mem #(.DEPTH(FILE_SLOTS), .AW(SAW), .DW(REC_W)) u_mem (
    .clk(clk), .we(rec_we), .waddr(slot_idx), .wdata(rec_wdata),
    .raddr(slot_raddr), .rdata(rec_rdata)
  );

  aft_divider u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  // device threshold memory
  always_ff @(posedge clk) begin
    if (dev_we) begin
      dev_limit_mem[dev_waddr] <= dev_wdata;
    end
    dev_rd_r <= dev_limit_mem[dev_raddr];
  end

  always_comb begin
    rec_we = 1'b0;
    rec_wdata = {rec_dirty, rec_limit, rec_dev};
    dev_we = 1'b0;
    dev_waddr = rec_dev;
    dev_wdata = lim_r;
    div_req = '0;
    div_req.dividend = {32'd0, rec_limit} * {32'd0, lat_high_r};
    div_req.divisor = item_r.elapsed_us;
    if (state_r == S_EXEC && slot_in_range) begin
      if (item_r.operation == OP_OPEN) begin
        rec_we = 1'b1;
        rec_wdata = {33'd0, (dev_known_r[dev_idx] ? dev_rd_r : lim_init_r), dev_idx};
        dev_we = !dev_known_r[dev_idx];
        dev_waddr = dev_idx;
        dev_wdata = lim_init_r;
      end else if (item_r.operation == OP_WRITE && slot_valid_r[slot_idx]) begin
        rec_we = 1'b1;
        rec_wdata = {(dirty_sum >= {1'b0, rec_limit}) ? 33'd0 : dirty_sum,
                     rec_limit, rec_dev};
      end else if (item_r.operation == OP_SYNC && slot_valid_r[slot_idx] &&
                   item_r.sync_ok && ({1'b0, item_r.elapsed_us} > high_x2)) begin
        div_req.start = 1'b1;
      end
    end
    if (state_r == S_OUT) begin
      rec_we = 1'b1;
      rec_wdata = {rec_dirty, lim_r, rec_dev};
      dev_we = 1'b1;
    end
  end

  // result and next state of the execute cycle
  always_comb begin
    exec_out = '0;
    exec_next = S_ADJ;
    exec_kind = KIND_SAME;
    if (!slot_in_range) begin
      exec_next = S_IDLE;
    end else begin
      case (item_r.operation)
        OP_OPEN: begin
          exec_out.tracked = 1'b1;
          exec_out.flush_limit = dev_known_r[dev_idx] ? dev_rd_r : lim_init_r;
          exec_next = S_IDLE;
        end
        OP_CLOSE: begin
          exec_next = S_IDLE;
        end
        OP_WRITE: begin
          exec_next = S_IDLE;
          if (slot_valid_r[slot_idx]) begin
            exec_out.tracked = 1'b1;
            exec_out.flush_limit = rec_limit;
            if (dirty_sum >= {1'b0, rec_limit}) begin
              exec_out.sync_request = 1'b1;
            end else begin
              exec_out.dirty_bytes = dirty_sum;
            end
          end
        end
        default: begin
          if (!slot_valid_r[slot_idx]) begin
            exec_next = S_IDLE;
          end else if (!item_r.sync_ok) begin
            exec_out.tracked = 1'b1;
            exec_out.dirty_bytes = rec_dirty;
            exec_out.flush_limit = rec_limit;
            exec_next = S_IDLE;
          end else if ({1'b0, item_r.elapsed_us} > high_x2) begin
            exec_kind = KIND_DEC;
            exec_next = S_DIV;
          end else if (item_r.elapsed_us > lat_high_r) begin
            exec_kind = KIND_DEC;
            exec_next = S_MUL;
          end else if (item_r.elapsed_us < lat_low_r) begin
            exec_kind = KIND_INC;
            exec_next = S_MUL;
          end
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if ((state_r == S_EXEC && exec_next == S_IDLE) || state_r == S_OUT) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_comb begin
    adj_lim = lim_r;
    if (kind_r == KIND_DEC) begin
      adj_lim = (lim_r < lim_floor_r) ? lim_floor_r : lim_r;
      adj_lim = {adj_lim[31:12], 12'd0};
    end else if (kind_r == KIND_INC) begin
      adj_lim = (mul_q_r > {1'b0, lim_ceil_r}) ? lim_ceil_r : mul_q_r[31:0];
      adj_lim = {adj_lim[31:12], 12'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      slot_valid_r <= '0;
      dev_known_r <= '0;
      lim_init_r <= 32'd1048576;
      lim_floor_r <= 32'd1048576;
      lim_ceil_r <= 32'h8000_0000;
      lat_high_r <= 32'd1100000;
      lat_low_r <= 32'd900000;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_INITIAL: lim_init_r <= cfg_data;
          REG_FLOOR:   lim_floor_r <= cfg_data;
          REG_CEILING: lim_ceil_r <= cfg_data;
          REG_HIGH:    lat_high_r <= cfg_data;
          REG_LOW:     lat_low_r <= cfg_data;
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            item_r <= in_data;
            state_r <= S_READ;
          end
        end
        S_READ: state_r <= S_EXEC;
        S_EXEC: begin
          out_r <= exec_out;
          kind_r <= exec_kind;
          lim_r <= rec_limit;
          state_r <= exec_next;
          if (slot_in_range) begin
            if (item_r.operation == OP_OPEN) begin
              slot_valid_r[slot_idx] <= 1'b1;
              dev_known_r[dev_idx] <= 1'b1;
            end else if (item_r.operation == OP_CLOSE) begin
              slot_valid_r[slot_idx] <= 1'b0;
            end
          end
        end
        S_DIV: begin
          // hold until the quotient is ready; it fits 32 bits since E > 2H
          if (div_rsp.done) begin
            lim_r <= div_rsp.quotient[31:0];
            state_r <= S_ADJ;
          end
        end
        S_MUL: begin
          // split the limit into halves to keep each product narrow
          pp_lo_r <= {37'd0, lim_r[15:0]} * {16'd0, mul_k};
          pp_hi_r <= {37'd0, lim_r[31:16]} * {16'd0, mul_k};
          state_r <= S_SUM;
        end
        S_SUM: begin
          if (kind_r == KIND_DEC) begin
            lim_r <= mul_sum[67:36];
          end else begin
            mul_q_r <= mul_sum[68:36];
          end
          state_r <= S_ADJ;
        end
        S_ADJ: begin
          lim_r <= adj_lim;
          state_r <= S_OUT;
        end
        S_OUT: begin
          dev_known_r[rec_dev] <= 1'b1;
          out_r <= {1'b1, 1'b0, rec_dirty, lim_r, kind_r};
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign out_valid = out_valid_r;
  assign out_data = out_r;
  assign cfg_ready = (state_r == S_IDLE);

  `AFT_ASSERT_IMP(a_one_busy, clk, rst_n, state_r != S_IDLE, in_stall)
  `AFT_ASSERT_IMP(a_cfg_idle, clk, rst_n, cfg_ready, state_r == S_IDLE)
  `AFT_ASSERT_NXT(a_div_done, clk, rst_n, state_r == S_DIV && div_rsp.done,
                  state_r == S_ADJ)
  `AFT_ASSERT_IMP(a_kind_ok, clk, rst_n, out_valid, out_data.adjust_kind != 2'd3)
endmodule
`default_nettype wire

>>> hdl/aft_divider.sv
// ----------------------------------------------------------------------------
// aft_divider
// Restoring divider, 64 by 32 bits, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module aft_divider (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire aft_pkg::div_req_t req,
  output aft_pkg::div_rsp_t      rsp
);
  import aft_pkg::*;

  logic        busy_r;
  logic [6:0]  cnt_r;
  logic [63:0] quo_r;
  logic [32:0] rem_r;
  logic [31:0] dsr_r;
  logic        done_r;
  logic [32:0] shifted;
  logic [33:0] diff;

  always_comb begin
    shifted = {rem_r[31:0], quo_r[63]};
    diff = {1'b0, shifted} - {2'b0, dsr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd64;
        quo_r  <= req.dividend;
        rem_r  <= '0;
        dsr_r  <= req.divisor;
      end else if (busy_r) begin
        // shift in one dividend bit, subtract when it fits
        if (!diff[33]) begin
          rem_r <= diff[32:0];
          quo_r <= {quo_r[62:0], 1'b1};
        end else begin
          rem_r <= shifted;
          quo_r <= {quo_r[62:0], 1'b0};
        end
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quotient = quo_r;
endmodule
`default_nettype wire

>>> hdl/aft_slot_mem.sv
// ----------------------------------------------------------------------------
// aft_slot_mem
// Per-slot record memory: dirty count, threshold and device index.
// ----------------------------------------------------------------------------
`default_nettype none
module aft_slot_mem #(
  parameter int DEPTH = 64,
  parameter int AW = 6,
  parameter int DW = 68
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
